FILE: hdl/lspe_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and a helper function of the line sensor position estimator.
package lspe_pkg;

  localparam int SENSORS        = 5;
  localparam int ADC_FULL_SCALE = 4095;
  localparam int NORM_MAX       = 1000;

  localparam int SAMP_W     = 12;
  localparam int CAL_W      = 16;
  localparam int SMOOTH_W   = 25;
  localparam int FRAC_W     = 15;
  localparam int LVL_W      = 10;
  localparam int SUM_W      = 13;
  localparam int POS_W      = 16;
  localparam int WGT_W      = 16;
  localparam int ALPHA_W    = 16;
  localparam int NRM_W      = 12;
  localparam int NRM_NUM_W  = 24;
  localparam int DIV_NUM_W  = 30;
  localparam int DIV_DEN_W  = 16;
  localparam int WSUM_W     = 30;
  localparam int IDX_W      = $clog2(SENSORS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int ALPHA_ONE    = 32768;
  localparam int CAL_OK_SPAN  = 20;
  localparam int CAL_MIN_SPAN = 4;
  localparam int THR_RESET    = 500;

  typedef enum logic [1:0] {
    ACT_START_CAL = 2'd0,
    ACT_CAL_FRAME = 2'd1,
    ACT_END_CAL   = 2'd2,
    ACT_MEASURE   = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA   = 3'd0,
    REG_THRESH  = 3'd1,
    REG_WEIGHT0 = 3'd2,
    REG_WEIGHT1 = 3'd3,
    REG_WEIGHT2 = 3'd4,
    REG_WEIGHT3 = 3'd5,
    REG_WEIGHT4 = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    action_t             action;
    logic [SAMP_W-1:0]   sample0;
    logic [SAMP_W-1:0]   sample1;
    logic [SAMP_W-1:0]   sample2;
    logic [SAMP_W-1:0]   sample3;
    logic [SAMP_W-1:0]   sample4;
  } in_word_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    line_found;
    logic [SUM_W-1:0]        signal_total;
    logic                    calib_valid;
    logic [LVL_W-1:0]        level0;
    logic [LVL_W-1:0]        level1;
    logic [LVL_W-1:0]        level2;
    logic [LVL_W-1:0]        level3;
    logic [LVL_W-1:0]        level4;
  } out_word_t;

  typedef struct packed {
    logic [CAL_W-1:0]    cal_min;
    logic [CAL_W-1:0]    cal_max;
    logic [SMOOTH_W-1:0] smooth;
  } cal_ent_t;

  localparam cal_ent_t ENT_RESET = '{cal_min: '1, cal_max: '0, smooth: '0};

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    cal_ent_t         data;
  } mem_wr_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [WGT_W-1:0] wgt_reset(input int i);
    return WGT_W'((2 * i - (SENSORS - 1)) * 500);
  endfunction

endpackage

FILE: hdl/lspe_state_mem.sv
`timescale 1ns / 1ps
// Per-sensor calibration and filter state memory with registered read and entry valid bits.
module lspe_state_mem import lspe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output cal_ent_t         rd_data,
  input  mem_wr_t          wr
);

  cal_ent_t             mem [SENSORS];
  cal_ent_t             rd_raw_r;
  logic [SENSORS-1:0]   vld_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_raw_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // An entry never written reads as its reset contents.
  assign rd_data = rd_vld_r ? rd_raw_r : ENT_RESET;

endmodule

FILE: hdl/lspe_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider that retires one quotient bit per cycle.
module lspe_div import lspe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  assign trial = {rem_r, quo_r[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      den_r <= req.den;
      quo_r <= req.num;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

FILE: hdl/line_sensor_position_estimator.sv
`timescale 1ns / 1ps
// Line sensor position estimator top level: sequencer, arithmetic and result register.
// A measure word normalises its five sensors in turn with the 30-step serial divider and
// then, if a line is found, divides once more for the centroid position; calibration
// words skip the divider. One word is worked on at a time; a finished result waits in the
// output register while the next word is taken. Synchronous active-low reset clears the
// calibration, filter state, held position and registers to their defaults.
module line_sensor_position_estimator import lspe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_RD   = 10'b0000000010,
    ST_CALC = 10'b0000000100,
    ST_DIV  = 10'b0000001000,
    ST_FLT1 = 10'b0000010000,
    ST_FLT2 = 10'b0000100000,
    ST_ACC  = 10'b0001000000,
    ST_FIN  = 10'b0010000000,
    ST_PDIV = 10'b0100000000,
    ST_DONE = 10'b1000000000
  } state_t;

  state_t                    state_r;
  logic [IDX_W-1:0]          idx_r;
  action_t                   act_r;
  logic [SAMP_W-1:0]         samp_r [SENSORS];
  logic [ALPHA_W-1:0]        alpha_r;
  logic [SUM_W-1:0]          thr_r;
  logic signed [WGT_W-1:0]   wgt_r [SENSORS];
  cal_ent_t                  ent_r;
  logic [NRM_W-1:0]          norm_r;
  logic [27:0]               p1_r;
  logic [LVL_W-1:0]          lvl_r [SENSORS];
  logic [SUM_W-1:0]          sum_r;
  logic signed [WSUM_W-1:0]  wsum_r;
  logic                      found_r;
  logic                      ok_acc_r;
  logic                      cal_ok_r;
  logic signed [POS_W-1:0]   held_r;
  out_word_t                 out_r;
  logic                      out_valid_r;

  logic                      accept;
  logic                      last;
  logic                      rd_en;
  cal_ent_t                  rd_data;
  mem_wr_t                   mem_wr;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;
  logic [SAMP_W-1:0]         raw;
  logic [CAL_W-1:0]          lo;
  logic [CAL_W-1:0]          hi;
  logic                      span_small;
  logic                      below;
  logic [SAMP_W-1:0]         mul_a;
  logic [NRM_NUM_W-1:0]      nrm_num;
  logic [DIV_DEN_W-1:0]      nrm_den;
  logic                      nrm_zero;
  logic [ALPHA_W-1:0]        alpha_sat;
  logic [ALPHA_W-1:0]        one_minus;
  logic [40:0]               p2;
  logic [28:0]               sm_sum;
  logic [SMOOTH_W-1:0]       new_s;
  logic [LVL_W-1:0]          ip_raw;
  logic [LVL_W-1:0]          ip;
  logic                      found_c;
  logic                      wsum_neg;
  logic [WSUM_W-1:0]         wsum_abs;
  logic [POS_W-1:0]          pos_q;
  logic                      out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign last      = (idx_r == IDX_W'(SENSORS - 1));
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  assign raw        = samp_r[idx_r];
  assign lo         = rd_data.cal_min;
  assign hi         = rd_data.cal_max;
  assign span_small = {1'b0, hi} <= ({1'b0, lo} + 17'(CAL_MIN_SPAN));
  assign below      = {{(CAL_W - SAMP_W){1'b0}}, raw} < lo;
  assign nrm_zero   = !span_small && below;
  assign mul_a      = span_small ? raw : (raw - lo[SAMP_W-1:0]);
  assign nrm_num    = NRM_NUM_W'(mul_a) * NRM_NUM_W'(NORM_MAX);
  assign nrm_den    = span_small ? DIV_DEN_W'(ADC_FULL_SCALE) : (hi - lo);

  assign alpha_sat  = (alpha_r > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : alpha_r;
  assign one_minus  = ALPHA_W'(ALPHA_ONE) - alpha_sat;
  assign p2         = 41'(one_minus) * 41'(ent_r.smooth);
  assign sm_sum     = 29'(p1_r) + 29'(p2[40:FRAC_W]);
  assign new_s      = sm_sum[SMOOTH_W-1:0];
  assign ip_raw     = new_s[SMOOTH_W-1:FRAC_W];
  assign ip         = (ip_raw > LVL_W'(NORM_MAX)) ? LVL_W'(NORM_MAX) : ip_raw;

  assign found_c    = sum_r >= thr_r;
  assign wsum_neg   = wsum_r[WSUM_W-1];
  assign wsum_abs   = wsum_neg ? WSUM_W'(-wsum_r) : WSUM_W'(wsum_r);
  assign pos_q      = div_rsp.quo[POS_W-1:0];

  assign rd_en = (state_r == ST_RD);

  always_comb begin
    mem_wr.en   = 1'b0;
    mem_wr.addr = idx_r;
    mem_wr.data = rd_data;
    if (state_r == ST_CALC && act_r == ACT_START_CAL) begin
      mem_wr.en           = 1'b1;
      mem_wr.data.cal_min = '1;
      mem_wr.data.cal_max = '0;
    end else if (state_r == ST_CALC && act_r == ACT_CAL_FRAME) begin
      mem_wr.en           = 1'b1;
      mem_wr.data.cal_min = below ? CAL_W'(raw) : lo;
      mem_wr.data.cal_max = ({{(CAL_W - SAMP_W){1'b0}}, raw} > hi) ? CAL_W'(raw) : hi;
    end else if (state_r == ST_FLT2) begin
      mem_wr.en          = 1'b1;
      mem_wr.data        = ent_r;
      mem_wr.data.smooth = new_s;
    end
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = DIV_NUM_W'(nrm_num);
    div_req.den   = nrm_den;
    if (state_r == ST_CALC) begin
      div_req.start = (act_r == ACT_MEASURE) && !nrm_zero;
    end else if (state_r == ST_FIN) begin
      div_req.start = (act_r == ACT_MEASURE) && found_c && (sum_r != '0);
      div_req.num   = wsum_abs;
      div_req.den   = DIV_DEN_W'(sum_r);
    end
  end

  lspe_state_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data),
    .wr      (mem_wr)
  );

  lspe_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_W'(ALPHA_ONE);
      thr_r   <= SUM_W'(THR_RESET);
      for (int i = 0; i < SENSORS; i++) begin
        wgt_r[i] <= wgt_reset(i);
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ALPHA:  alpha_r <= cfg_data;
        REG_THRESH: thr_r   <= cfg_data[SUM_W-1:0];
        default: begin
          if (cfg_index >= REG_WEIGHT0 && cfg_index <= REG_WEIGHT4) begin
            wgt_r[IDX_W'(cfg_index - REG_WEIGHT0)] <= cfg_data;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r     <= in_word.action;
      samp_r[0] <= in_word.sample0;
      samp_r[1] <= in_word.sample1;
      samp_r[2] <= in_word.sample2;
      samp_r[3] <= in_word.sample3;
      samp_r[4] <= in_word.sample4;
    end
    if (state_r == ST_CALC) begin
      ent_r <= rd_data;
    end
    if (state_r == ST_FLT1) begin
      p1_r <= 28'(alpha_sat) * 28'(norm_r);
    end
    if (state_r == ST_DONE && out_free) begin
      out_r.position     <= held_r;
      out_r.line_found   <= found_r;
      out_r.signal_total <= sum_r;
      out_r.calib_valid  <= cal_ok_r;
      out_r.level0       <= lvl_r[0];
      out_r.level1       <= lvl_r[1];
      out_r.level2       <= lvl_r[2];
      out_r.level3       <= lvl_r[3];
      out_r.level4       <= lvl_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      norm_r      <= '0;
      sum_r       <= '0;
      wsum_r      <= '0;
      found_r     <= 1'b0;
      ok_acc_r    <= 1'b1;
      cal_ok_r    <= 1'b0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SENSORS; i++) begin
        lvl_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            idx_r    <= '0;
            sum_r    <= '0;
            wsum_r   <= '0;
            found_r  <= 1'b0;
            ok_acc_r <= 1'b1;
            for (int i = 0; i < SENSORS; i++) begin
              lvl_r[i] <= '0;
            end
            state_r <= ST_RD;
          end
        end
        ST_RD: state_r <= ST_CALC;
        ST_CALC: begin
          if (act_r == ACT_MEASURE) begin
            if (nrm_zero) begin
              norm_r  <= '0;
              state_r <= ST_FLT1;
            end else begin
              state_r <= ST_DIV;
            end
          end else begin
            if (act_r == ACT_END_CAL) begin
              ok_acc_r <= ok_acc_r && ({1'b0, hi} > ({1'b0, lo} + 17'(CAL_OK_SPAN)));
            end
            idx_r   <= last ? idx_r : idx_r + IDX_W'(1);
            state_r <= last ? ST_FIN : ST_RD;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            norm_r  <= (div_rsp.quo > DIV_NUM_W'(NORM_MAX)) ? NRM_W'(NORM_MAX)
                                                              : div_rsp.quo[NRM_W-1:0];
            state_r <= ST_FLT1;
          end
        end
        ST_FLT1: state_r <= ST_FLT2;
        ST_FLT2: begin
          lvl_r[idx_r] <= ip;
          sum_r        <= sum_r + SUM_W'(ip);
          state_r      <= ST_ACC;
        end
        ST_ACC: begin
          wsum_r  <= wsum_r + WSUM_W'(wgt_r[idx_r]) * WSUM_W'($signed({1'b0, lvl_r[idx_r]}));
          idx_r   <= last ? idx_r : idx_r + IDX_W'(1);
          state_r <= last ? ST_FIN : ST_RD;
        end
        ST_FIN: begin
          state_r <= ST_DONE;
          unique case (act_r)
            ACT_START_CAL: cal_ok_r <= 1'b0;
            ACT_END_CAL:   cal_ok_r <= ok_acc_r;
            ACT_MEASURE: begin
              found_r <= found_c;
              if (found_c && sum_r != '0) begin
                state_r <= ST_PDIV;
              end
            end
            default: ;
          endcase
        end
        ST_PDIV: begin
          if (div_rsp.done) begin
            held_r  <= wsum_neg ? -$signed(pos_q) : $signed(pos_q);
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_W'(SENSORS - 1))
    else $error("Sensor index out of range.");

  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && mem_wr.en) |-> (mem_wr.addr != idx_r))
    else $error("State memory read and write hit the same entry.");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("Divider started while busy.");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV || state_r == ST_PDIV))
    else $error("Divider finished with no one waiting.");

endmodule
